FILE: rtl/core/swmm_pkg.sv
package swmm_pkg;

    // result field width and converter reference in millivolts
    localparam int OUT_W = 12;
    localparam int VREF_W = 12;
    localparam logic [VREF_W-1:0] VREF_MV = 12'd3300;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_CONV = 4'b0100,
        ST_HOLD = 4'b1000
    } state_t;

    // which value goes through the divider
    typedef enum logic [1:0] {
        SEL_SAMPLE = 2'd0,
        SEL_MEAN   = 2'd1,
        SEL_MIN    = 2'd2,
        SEL_MAX    = 2'd3
    } conv_sel_t;

    // divider status toward the sequencer
    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] quot;
    } div_res_t;

endpackage

FILE: rtl/core/swmm_cell.sv
module swmm_cell #(
    parameter int ADC_BITS = 12
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  logic [ADC_BITS-1:0] d,
    output logic [ADC_BITS-1:0] q
);

    logic [ADC_BITS-1:0] code_reg;
    logic [ADC_BITS-1:0] code_next;

    // take the neighbor's code on every shift
    always_comb begin
        code_next = shift_en ? d : code_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_reg <= '0;
        end else begin
            code_reg <= code_next;
        end
    end

    assign q = code_reg;

endmodule

FILE: rtl/core/swmm_div.sv
module swmm_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 28,
    parameter int RCP_W = 25
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [NUM_W-1:0]    num,
    input  logic [DEN_W-1:0]    den2,
    input  logic [RCP_W-1:0]    rcp,
    output swmm_pkg::div_res_t  res
);

    localparam int PRD_W  = NUM_W + RCP_W;
    localparam int BACK_W = swmm_pkg::OUT_W + DEN_W;

    logic [NUM_W-1:0]               num_reg, num_next;
    logic [DEN_W-1:0]               den2_reg, den2_next;
    logic [RCP_W-1:0]               rcp_reg, rcp_next;
    logic [swmm_pkg::OUT_W-1:0]     est_reg, est_next;
    logic [swmm_pkg::OUT_W-1:0]     quot_reg, quot_next;
    logic                           mul_reg, mul_next;
    logic                           fix_reg, fix_next;
    logic                           done_reg, done_next;
    logic [PRD_W-1:0]               prod;
    logic [BACK_W-1:0]              back;
    logic [NUM_W-1:0]               rem;

    // division by a constant: reciprocal estimate, then one correction step
    // rcp is floor(2^NUM_W / den2), so the estimate is the quotient or one below it
    always_comb begin
        num_next  = num_reg;
        den2_next = den2_reg;
        rcp_next  = rcp_reg;
        est_next  = est_reg;
        quot_next = quot_reg;
        mul_next  = start;
        fix_next  = mul_reg;
        done_next = fix_reg;
        prod      = PRD_W'(num_reg) * PRD_W'(rcp_reg);
        back      = BACK_W'(est_reg) * BACK_W'(den2_reg);
        rem       = num_reg - NUM_W'(back);
        if (start) begin
            num_next  = num;
            den2_next = den2;
            rcp_next  = rcp;
        end
        if (mul_reg) begin
            est_next = prod[NUM_W +: swmm_pkg::OUT_W];
        end
        if (fix_reg) begin
            quot_next = (rem >= NUM_W'(den2_reg)) ? est_reg + 1'b1 : est_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= mul_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
        end
        num_reg  <= num_next;
        den2_reg <= den2_next;
        rcp_reg  <= rcp_next;
        est_reg  <= est_next;
        quot_reg <= quot_next;
    end

    assign res.done = done_reg;
    assign res.quot = quot_reg;

endmodule

FILE: rtl/core/sliding_window_min_max_average.sv
// an item passes through the scan, the four conversions and the hold state before its
//   result reaches the m_ port; one item is processed at a time: the ring of cells
//   rotates once per item and a shared divider converts four values in turn
// a finished result waits in the output register while the next item is accepted
// reset (aresetn low, synchronous) clears every window cell, the running sum and the
//   handshake state; no clearing pass is needed
module sliding_window_min_max_average #(
    parameter int WINDOW   = 100,
    parameter int ADC_BITS = 12
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [ADC_BITS-1:0]          s_sample_raw,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [swmm_pkg::OUT_W-1:0]   m_sample_mv,
    output logic [swmm_pkg::OUT_W-1:0]   m_average_mv,
    output logic [swmm_pkg::OUT_W-1:0]   m_minimum_mv,
    output logic [swmm_pkg::OUT_W-1:0]   m_maximum_mv
);

    localparam int SUM_W = ADC_BITS + $clog2(WINDOW);
    localparam int NUM_W = SUM_W + swmm_pkg::VREF_W + 2;
    localparam int PROD_W = SUM_W + swmm_pkg::VREF_W;
    localparam int DEN_W = SUM_W + 1;
    localparam int RCP_W = NUM_W - ADC_BITS + 1;
    localparam int CNT_W = $clog2(WINDOW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WINDOW - 1);
    localparam logic [63:0] FS64 = (64'd1 << ADC_BITS) - 64'd1;
    localparam logic [SUM_W-1:0] DEN_ONE = SUM_W'(FS64);
    localparam logic [SUM_W-1:0] DEN_WIN = SUM_W'(FS64 * 64'(WINDOW));
    // reciprocals of twice each divisor, scaled by 2^NUM_W
    localparam logic [RCP_W-1:0] RCP_ONE = RCP_W'((64'd1 << NUM_W) / (64'd2 * FS64));
    localparam logic [RCP_W-1:0] RCP_WIN =
        RCP_W'((64'd1 << NUM_W) / (64'd2 * FS64 * 64'(WINDOW)));

    swmm_pkg::state_t           state_reg, state_next;
    swmm_pkg::conv_sel_t        sel_reg, sel_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [SUM_W-1:0]           sum_reg, sum_next;
    logic [ADC_BITS-1:0]        code_reg, code_next;
    logic [ADC_BITS-1:0]        min_reg, min_next;
    logic [ADC_BITS-1:0]        max_reg, max_next;
    logic [swmm_pkg::OUT_W-1:0] r_smp_reg, r_smp_next;
    logic [swmm_pkg::OUT_W-1:0] r_avg_reg, r_avg_next;
    logic [swmm_pkg::OUT_W-1:0] r_min_reg, r_min_next;
    logic [swmm_pkg::OUT_W-1:0] r_max_reg, r_max_next;
    logic                       mv_reg, mv_next;
    logic [swmm_pkg::OUT_W-1:0] o_smp_reg, o_smp_next;
    logic [swmm_pkg::OUT_W-1:0] o_avg_reg, o_avg_next;
    logic [swmm_pkg::OUT_W-1:0] o_min_reg, o_min_next;
    logic [swmm_pkg::OUT_W-1:0] o_max_reg, o_max_next;

    logic                       accept;
    logic                       shift_en;
    logic [ADC_BITS-1:0]        ring_in;
    logic [ADC_BITS-1:0]        tap;
    logic [ADC_BITS-1:0]        cell_q [WINDOW];
    logic                       div_start;
    logic [SUM_W-1:0]           conv_x;
    logic [SUM_W-1:0]           conv_den;
    logic [RCP_W-1:0]           conv_rcp;
    logic [PROD_W-1:0]          conv_prod;
    logic [NUM_W-1:0]           div_num;
    logic [DEN_W-1:0]           div_den2;
    swmm_pkg::div_res_t         div_res;

    assign accept = s_valid && s_ready;
    assign s_ready = (state_reg == swmm_pkg::ST_IDLE);
    assign tap = cell_q[WINDOW-1];

    // ring of cells: new item enters on accept, then one full rotation for the scan
    assign shift_en = accept || (state_reg == swmm_pkg::ST_SCAN);
    assign ring_in = accept ? s_sample_raw : tap;

    for (genvar i = 0; i < WINDOW; i++) begin : g_cell
        if (i == 0) begin : g_head
            swmm_cell #(.ADC_BITS(ADC_BITS)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d        (ring_in),
                .q        (cell_q[i])
            );
        end else begin : g_body
            swmm_cell #(.ADC_BITS(ADC_BITS)) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d        (cell_q[i-1]),
                .q        (cell_q[i])
            );
        end
    end

    // operand of the divider: round(x * vref / den) as (2*x*vref + den) / (2*den)
    // follows the next selection so it is in place when a conversion starts
    always_comb begin
        unique case (sel_next)
            swmm_pkg::SEL_SAMPLE: begin
                conv_x   = SUM_W'(code_reg);
                conv_den = DEN_ONE;
                conv_rcp = RCP_ONE;
            end
            swmm_pkg::SEL_MEAN: begin
                conv_x   = sum_reg;
                conv_den = DEN_WIN;
                conv_rcp = RCP_WIN;
            end
            swmm_pkg::SEL_MIN: begin
                conv_x   = SUM_W'(min_reg);
                conv_den = DEN_ONE;
                conv_rcp = RCP_ONE;
            end
            swmm_pkg::SEL_MAX: begin
                conv_x   = SUM_W'(max_reg);
                conv_den = DEN_ONE;
                conv_rcp = RCP_ONE;
            end
            default: begin
                conv_x   = '0;
                conv_den = DEN_ONE;
                conv_rcp = RCP_ONE;
            end
        endcase
        conv_prod = PROD_W'(conv_x) * PROD_W'(swmm_pkg::VREF_MV);
        div_num   = NUM_W'({conv_prod, 1'b0}) + NUM_W'(conv_den);
        div_den2  = {conv_den, 1'b0};
    end

    swmm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .RCP_W(RCP_W)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den2    (div_den2),
        .rcp     (conv_rcp),
        .res     (div_res)
    );

    // sequencer
    always_comb begin
        state_next = state_reg;
        sel_next   = sel_reg;
        cnt_next   = cnt_reg;
        sum_next   = sum_reg;
        code_next  = code_reg;
        min_next   = min_reg;
        max_next   = max_reg;
        r_smp_next = r_smp_reg;
        r_avg_next = r_avg_reg;
        r_min_next = r_min_reg;
        r_max_next = r_max_reg;
        mv_next    = mv_reg;
        o_smp_next = o_smp_reg;
        o_avg_next = o_avg_reg;
        o_min_next = o_min_reg;
        o_max_next = o_max_reg;
        div_start  = 1'b0;

        // output register drains on its own
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            swmm_pkg::ST_IDLE: begin
                if (accept) begin
                    sum_next   = sum_reg - SUM_W'(tap) + SUM_W'(s_sample_raw);
                    code_next  = s_sample_raw;
                    min_next   = '1;
                    max_next   = '0;
                    cnt_next   = '0;
                    state_next = swmm_pkg::ST_SCAN;
                end
            end
            swmm_pkg::ST_SCAN: begin
                if (tap < min_reg) begin
                    min_next = tap;
                end
                if (tap > max_reg) begin
                    max_next = tap;
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    sel_next   = swmm_pkg::SEL_SAMPLE;
                    state_next = swmm_pkg::ST_CONV;
                end
            end
            swmm_pkg::ST_CONV: begin
                if (div_res.done) begin
                    unique case (sel_reg)
                        swmm_pkg::SEL_SAMPLE: r_smp_next = div_res.quot;
                        swmm_pkg::SEL_MEAN:   r_avg_next = div_res.quot;
                        swmm_pkg::SEL_MIN:    r_min_next = div_res.quot;
                        swmm_pkg::SEL_MAX:    r_max_next = div_res.quot;
                        default:              r_smp_next = div_res.quot;
                    endcase
                    if (sel_reg == swmm_pkg::SEL_MAX) begin
                        state_next = swmm_pkg::ST_HOLD;
                    end else begin
                        sel_next = swmm_pkg::conv_sel_t'(sel_reg + 2'd1);
                    end
                end
            end
            swmm_pkg::ST_HOLD: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    o_smp_next = r_smp_reg;
                    o_avg_next = r_avg_reg;
                    o_min_next = r_min_reg;
                    o_max_next = r_max_reg;
                    state_next = swmm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swmm_pkg::ST_IDLE;
            end
        endcase

        // first conversion starts as the scan ends, the next ones as each finishes
        if ((state_reg == swmm_pkg::ST_SCAN) && (cnt_reg == CNT_LAST)) begin
            div_start = 1'b1;
        end else if ((state_reg == swmm_pkg::ST_CONV) && div_res.done
                     && (sel_reg != swmm_pkg::SEL_MAX)) begin
            div_start = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= swmm_pkg::ST_IDLE;
            sel_reg   <= swmm_pkg::SEL_SAMPLE;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            mv_reg    <= mv_next;
        end
        code_reg  <= code_next;
        min_reg   <= min_next;
        max_reg   <= max_next;
        r_smp_reg <= r_smp_next;
        r_avg_reg <= r_avg_next;
        r_min_reg <= r_min_next;
        r_max_reg <= r_max_next;
        o_smp_reg <= o_smp_next;
        o_avg_reg <= o_avg_next;
        o_min_reg <= o_min_next;
        o_max_reg <= o_max_next;
    end

    assign m_valid      = mv_reg;
    assign m_sample_mv  = o_smp_reg;
    assign m_average_mv = o_avg_reg;
    assign m_minimum_mv = o_min_reg;
    assign m_maximum_mv = o_max_reg;

endmodule

FILE: rtl/core/swmm_checker.sv
module swmm_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [swmm_pkg::OUT_W-1:0]   m_sample_mv,
    input  logic [swmm_pkg::OUT_W-1:0]   m_average_mv,
    input  logic [swmm_pkg::OUT_W-1:0]   m_minimum_mv,
    input  logic [swmm_pkg::OUT_W-1:0]   m_maximum_mv
);

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_sample_mv)
            && $stable(m_average_mv) && $stable(m_minimum_mv) && $stable(m_maximum_mv)))
        else $error("stalled result changed");

    // one item in flight: ready drops after an accepted item
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("second item accepted while busy");

    // every value lies within the reference range
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sample_mv <= swmm_pkg::VREF_MV) && (m_average_mv <= swmm_pkg::VREF_MV)
            && (m_minimum_mv <= swmm_pkg::VREF_MV) && (m_maximum_mv <= swmm_pkg::VREF_MV))
        else $error("result above reference");

    // the mean and the new sample sit between the window extremes
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_minimum_mv <= m_average_mv) && (m_average_mv <= m_maximum_mv)
            && (m_minimum_mv <= m_sample_mv) && (m_sample_mv <= m_maximum_mv))
        else $error("window extremes out of order");

endmodule

bind sliding_window_min_max_average swmm_checker u_swmm_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_sample_mv  (m_sample_mv),
    .m_average_mv (m_average_mv),
    .m_minimum_mv (m_minimum_mv),
    .m_maximum_mv (m_maximum_mv)
);
